### src/qau_pkg.sv
`timescale 1ns / 1ps

package qau_pkg;

  typedef enum logic [1:0] {
    FUNC_PRODUCT   = 2'd0,
    FUNC_NORMALIZE = 2'd1,
    FUNC_CONJUGATE = 2'd2
  } func_t;

endpackage

### src/qau_in_if.sv
`timescale 1ns / 1ps

interface qau_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  qau_pkg::func_t      func;
  logic signed [W-1:0] a_w;
  logic signed [W-1:0] a_x;
  logic signed [W-1:0] a_y;
  logic signed [W-1:0] a_z;
  logic signed [W-1:0] b_w;
  logic signed [W-1:0] b_x;
  logic signed [W-1:0] b_y;
  logic signed [W-1:0] b_z;

  modport source (
    output valid, func, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
    input  ready
  );

  modport sink (
    input  valid, func, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
    output ready
  );
endinterface

### src/qau_out_if.sv
`timescale 1ns / 1ps

interface qau_out_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] r_w;
  logic signed [W-1:0] r_x;
  logic signed [W-1:0] r_y;
  logic signed [W-1:0] r_z;
  logic                zero_length;

  modport source (
    output valid, r_w, r_x, r_y, r_z, zero_length,
    input  ready
  );

  modport sink (
    input  valid, r_w, r_x, r_y, r_z, zero_length,
    output ready
  );
endinterface

### src/qau_norm_lane.sv
`timescale 1ns / 1ps

module qau_norm_lane #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*W-1:0] mag_sq,
  input  logic [2*W:0]   sum_sq,
  output logic [W-1:0]   mag
);

  localparam int SW   = 2 * W + 1;
  localparam int RW   = 2 * W + 2;
  localparam int QW   = 2 * W - 1;
  localparam int TW   = 2 * W + 1;
  localparam int NDIV = QW;
  localparam int NSQ  = W;

  logic [RW-1:0] d_rem [NDIV];
  logic [QW-1:0] d_q   [NDIV];
  logic [SW-1:0] d_s   [NDIV];

  logic [QW-1:0] s_rem [NSQ];
  logic [W-1:0]  s_q   [NSQ];

  // restoring divide: mag_sq * 2^(2W-2) / sum_sq, one quotient bit per stage
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [RW-1:0] prev_rem;
    logic [QW-1:0] prev_q;
    logic [SW-1:0] prev_s;
    logic          shift_bit;
    logic [RW-1:0] sh;
    logic          fit;

    if (k == 0) begin : g_first
      assign prev_rem  = RW'(mag_sq >> 1);
      assign prev_q    = '0;
      assign prev_s    = sum_sq;
      assign shift_bit = mag_sq[0];
    end else begin : g_next
      assign prev_rem  = d_rem[k-1];
      assign prev_q    = d_q[k-1];
      assign prev_s    = d_s[k-1];
      assign shift_bit = 1'b0;
    end

    assign sh  = {prev_rem[RW-2:0], shift_bit};
    assign fit = sh >= RW'(prev_s);

    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[k] <= fit ? sh - RW'(prev_s) : sh;
        d_q[k]   <= {prev_q[QW-2:0], fit};
        d_s[k]   <= prev_s;
      end
    end
  end

  // restoring square root of the quotient, one root bit per stage
  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    localparam int B = W - 1 - j;
    logic [QW-1:0] prev_rem;
    logic [W-1:0]  prev_q;
    logic [TW-1:0] trial;
    logic          fit;

    if (j == 0) begin : g_first
      assign prev_rem = d_q[NDIV-1];
      assign prev_q   = '0;
    end else begin : g_next
      assign prev_rem = s_rem[j-1];
      assign prev_q   = s_q[j-1];
    end

    assign trial = (TW'(prev_q) << (B + 1)) | (TW'(1) << (2 * B));
    assign fit   = TW'(prev_rem) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        s_rem[j] <= fit ? QW'(TW'(prev_rem) - trial) : prev_rem;
        s_q[j]   <= fit ? (prev_q | (W'(1) << B)) : prev_q;
      end
    end
  end

  // round half up of the doubled root
  logic [W:0] q_inc;
  assign q_inc = {1'b0, s_q[NSQ-1]} + (W+1)'(1);
  assign mag   = q_inc[W:1];

endmodule

### src/quaternion_arithmetic_unit.sv
`timescale 1ns / 1ps

// Quaternion unit on signed fixed-point components with two integer bits:
// Hamilton product, normalize and conjugate, all saturating. The datapath is
// a single pipeline that accepts one request per cycle unless it is held. The
// normalize path sets its depth: it divides by the sum of squares one
// quotient bit per stage and then takes a square root one bit per stage. The
// whole pipeline holds while the output register keeps a result not taken.
// Normalizing an all-zero quaternion returns zeros with zero_length set.
module quaternion_arithmetic_unit #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  qau_in_if.sink     req,
  qau_out_if.source  rsp
);

  localparam int W    = COMPONENT_WIDTH;
  localparam int F    = W - 2;
  localparam int PW   = 2 * W;
  localparam int SUMW = 2 * W + 2;
  localparam int LAT  = 3 * W - 1;

  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE  = W'(1) <<< F;

  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // stage 1: request register
  logic                v1;
  qau_pkg::func_t      f1;
  logic signed [W-1:0] a1 [4];
  logic signed [W-1:0] b1 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1    <= req.func;
      a1[0] <= req.a_w;
      a1[1] <= req.a_x;
      a1[2] <= req.a_y;
      a1[3] <= req.a_z;
      b1[0] <= req.b_w;
      b1[1] <= req.b_x;
      b1[2] <= req.b_y;
      b1[3] <= req.b_z;
    end
  end

  // stage 2: products and squares
  logic                 v2;
  qau_pkg::func_t       f2;
  logic signed [W-1:0]  a2  [4];
  logic signed [PW-1:0] p2  [16];
  logic [PW-1:0]        sq2 [4];
  logic [3:0]           sgn2;
  logic [W-1:0]         mag1 [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag1[i] = a1[i][W-1] ? W'(-a1[i]) : W'(a1[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2 <= f1;
      for (int i = 0; i < 4; i++) begin
        a2[i]   <= a1[i];
        sgn2[i] <= a1[i][W-1];
        sq2[i]  <= PW'(mag1[i]) * PW'(mag1[i]);
        for (int j = 0; j < 4; j++) begin
          p2[i*4+j] <= PW'(a1[i]) * PW'(b1[j]);
        end
      end
    end
  end

  // stage 3: sums, product rounding, conjugate, sum of squares
  function automatic logic signed [W-1:0] round_sat(input logic signed [SUMW-1:0] s);
    logic signed [SUMW-1:0] t;
    logic signed [SUMW-1:0] sh;
    t  = s + (SUMW'(1) <<< (F - 1));
    sh = t >>> F;
    if (sh > SUMW'(CMAX)) begin
      return CMAX;
    end else if (sh < SUMW'(CMIN)) begin
      return CMIN;
    end
    return W'(sh);
  endfunction

  function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] v);
    if (v == CMIN) begin
      return CMAX;
    end
    return -v;
  endfunction

  logic signed [SUMW-1:0] e2 [16];
  logic signed [W-1:0]    r2 [4];
  logic [PW:0]            s2;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      e2[i] = SUMW'(p2[i]);
    end
    s2 = (PW+1)'(sq2[0]) + (PW+1)'(sq2[1]) + (PW+1)'(sq2[2]) + (PW+1)'(sq2[3]);
    case (f2)
      qau_pkg::FUNC_PRODUCT: begin
        r2[0] = round_sat(e2[0]  - e2[5]  - e2[10] - e2[15]);
        r2[1] = round_sat(e2[1]  + e2[4]  + e2[11] - e2[14]);
        r2[2] = round_sat(e2[2]  - e2[7]  + e2[8]  + e2[13]);
        r2[3] = round_sat(e2[3]  + e2[6]  - e2[9]  + e2[12]);
      end
      qau_pkg::FUNC_CONJUGATE: begin
        r2[0] = a2[0];
        r2[1] = neg_sat(a2[1]);
        r2[2] = neg_sat(a2[2]);
        r2[3] = neg_sat(a2[3]);
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          r2[i] = '0;
        end
      end
    endcase
  end

  logic                v3;
  qau_pkg::func_t      f3;
  logic [4*W-1:0]      r3;
  logic                z3;
  logic [3:0]          sgn3;
  logic [PW:0]         s3;
  logic [PW-1:0]       sq3 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3   <= f2;
      r3   <= {r2[3], r2[2], r2[1], r2[0]};
      z3   <= s2 == '0;
      sgn3 <= sgn2;
      s3   <= s2;
      for (int i = 0; i < 4; i++) begin
        sq3[i] <= sq2[i];
      end
    end
  end

  // normalize lanes
  logic [W-1:0] nmag [4];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    qau_norm_lane #(
      .W (W)
    ) u_lane (
      .clk    (clk),
      .en     (en),
      .mag_sq (sq3[i]),
      .sum_sq (s3),
      .mag    (nmag[i])
    );
  end

  // side line matched to lane latency
  logic           sb_v   [LAT];
  qau_pkg::func_t sb_f   [LAT];
  logic [4*W-1:0] sb_r   [LAT];
  logic           sb_z   [LAT];
  logic [3:0]     sb_sgn [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) begin
        sb_v[k] <= 1'b0;
      end
    end else if (en) begin
      sb_v[0] <= v3;
      for (int k = 1; k < LAT; k++) begin
        sb_v[k] <= sb_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_f[0]   <= f3;
      sb_r[0]   <= r3;
      sb_z[0]   <= z3;
      sb_sgn[0] <= sgn3;
      for (int k = 1; k < LAT; k++) begin
        sb_f[k]   <= sb_f[k-1];
        sb_r[k]   <= sb_r[k-1];
        sb_z[k]   <= sb_z[k-1];
        sb_sgn[k] <= sb_sgn[k-1];
      end
    end
  end

  // output register
  logic                out_v;
  logic                out_norm;
  logic signed [W-1:0] out_r [4];
  logic                out_z;
  logic signed [W-1:0] fin_r [4];
  logic                fin_norm;

  always_comb begin
    fin_norm = sb_f[LAT-1] == qau_pkg::FUNC_NORMALIZE;
    for (int i = 0; i < 4; i++) begin
      if (!fin_norm) begin
        fin_r[i] = sb_r[LAT-1][i*W +: W];
      end else if (sb_z[LAT-1]) begin
        fin_r[i] = '0;
      end else if (sb_sgn[LAT-1][i]) begin
        fin_r[i] = -nmag[i];
      end else begin
        fin_r[i] = nmag[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= sb_v[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_norm <= fin_norm;
      out_z    <= fin_norm && sb_z[LAT-1];
      for (int i = 0; i < 4; i++) begin
        out_r[i] <= fin_r[i];
      end
    end
  end

  assign rsp.valid       = out_v;
  assign rsp.r_w         = out_r[0];
  assign rsp.r_x         = out_r[1];
  assign rsp.r_y         = out_r[2];
  assign rsp.r_z         = out_r[3];
  assign rsp.zero_length = out_z;

`ifndef SYNTHESIS
  a_zero_gives_zeros: assert property (
    @(posedge clk) disable iff (rst)
    out_v && out_z |-> (out_r[0] == '0 && out_r[1] == '0 &&
                        out_r[2] == '0 && out_r[3] == '0)
  ) else $error("zero_length result with nonzero components");

  a_flag_only_normalize: assert property (
    @(posedge clk) disable iff (rst)
    out_v && out_z |-> out_norm
  ) else $error("zero_length raised outside normalize");

  a_norm_bound: assert property (
    @(posedge clk) disable iff (rst)
    out_v && out_norm |-> (out_r[0] <= ONE && out_r[0] >= -ONE &&
                           out_r[1] <= ONE && out_r[1] >= -ONE &&
                           out_r[2] <= ONE && out_r[2] >= -ONE &&
                           out_r[3] <= ONE && out_r[3] >= -ONE)
  ) else $error("normalized component beyond unit magnitude");
`endif

endmodule

### tb/qau_checker.sv
`timescale 1ns / 1ps

module qau_checker #(
  parameter int W = 16
) (
  input  logic clk,
  input  logic rst,
  qau_in_if    req,
  qau_out_if   rsp,
  output int   errors,
  output int   pending
);

  localparam int F = W - 2;
  localparam longint CMAX = (longint'(1) << (W - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;

  typedef struct {
    logic signed [W-1:0] r [4];
    logic                zl;
  } quat_res_t;

  quat_res_t res_q [$];

  function automatic logic signed [W-1:0] clamp(longint v);
    if (v > CMAX) return CMAX[W-1:0];
    if (v < CMIN) return CMIN[W-1:0];
    return v[W-1:0];
  endfunction

  // round half up of an exact four-term sum
  function automatic logic signed [W-1:0] round_sum(longint p0, longint p1,
                                                    longint p2, longint p3);
    longint s;
    s = p0 + p1 + p2 + p3 + (longint'(1) << (F - 1));
    return clamp(s >>> F);
  endfunction

  // largest m with (2m-1)^2 * s <= mag^2 * 2^(2F+2): nearest, ties away
  function automatic longint unit_mag(longint mag, longint s);
    logic [127:0] rhs, lhs;
    longint lo, hi, mid, odd;
    rhs = 128'(mag * mag) << (2 * F + 2);
    lo = 0;
    hi = longint'(1) << F;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      odd = 2 * mid - 1;
      lhs = 128'(odd * odd) * 128'(s);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic quat_res_t quat_eval(qau_pkg::func_t fn, longint a [4], longint b [4]);
    quat_res_t o;
    longint s, m;
    for (int i = 0; i < 4; i++) o.r[i] = '0;
    o.zl = 1'b0;
    case (fn)
      qau_pkg::FUNC_PRODUCT: begin
        o.r[0] = round_sum(a[0]*b[0], -(a[1]*b[1]), -(a[2]*b[2]), -(a[3]*b[3]));
        o.r[1] = round_sum(a[0]*b[1], a[1]*b[0], a[2]*b[3], -(a[3]*b[2]));
        o.r[2] = round_sum(a[0]*b[2], -(a[1]*b[3]), a[2]*b[0], a[3]*b[1]);
        o.r[3] = round_sum(a[0]*b[3], a[1]*b[2], -(a[2]*b[1]), a[3]*b[0]);
      end
      qau_pkg::FUNC_NORMALIZE: begin
        s = 0;
        for (int i = 0; i < 4; i++) s += a[i] * a[i];
        if (s == 0) o.zl = 1'b1;
        else
          for (int i = 0; i < 4; i++) begin
            m = unit_mag(a[i] < 0 ? -a[i] : a[i], s);
            o.r[i] = clamp(a[i] < 0 ? -m : m);
          end
      end
      qau_pkg::FUNC_CONJUGATE: begin
        o.r[0] = clamp(a[0]);
        for (int i = 1; i < 4; i++) o.r[i] = clamp(-a[i]);
      end
      default: ;
    endcase
    return o;
  endfunction

  string names [4] = '{"r_w", "r_x", "r_y", "r_z"};

  always @(posedge clk) begin
    longint a [4], b [4];
    logic signed [W-1:0] got [4];
    quat_res_t e;
    int nerr;
    nerr = 0;
    if (rst) begin
      errors <= 0;
    end else begin
      if (req.valid && req.ready) begin
        a = '{req.a_w, req.a_x, req.a_y, req.a_z};
        b = '{req.b_w, req.b_x, req.b_y, req.b_z};
        res_q.push_back(quat_eval(req.func, a, b));
      end
      if (rsp.valid && rsp.ready) begin
        if (res_q.size() == 0) begin
          $error("unexpected result");
          nerr++;
        end else begin
          e = res_q.pop_front();
          got = '{rsp.r_w, rsp.r_x, rsp.r_y, rsp.r_z};
          for (int i = 0; i < 4; i++)
            if (got[i] !== e.r[i]) begin
              $error("%s expected %0d actual %0d", names[i], e.r[i], got[i]);
              nerr++;
            end
          if (rsp.zero_length !== e.zl) begin
            $error("zero_length expected %0d actual %0d", e.zl, rsp.zero_length);
            nerr++;
          end
        end
      end
      errors <= errors + nerr;
    end
    pending <= res_q.size();
  end
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int W = 16;
  localparam int N_RANDOM = 1500;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 5000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   idle_cnt;
  int   n_rsp;

  qau_in_if  #(.W(W)) req ();
  qau_out_if #(.W(W)) rsp ();

  quaternion_arithmetic_unit #(.COMPONENT_WIDTH(W)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  qau_checker #(.W(W)) u_chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst       = 1'b1;
    req.valid = 1'b0;
    req.func  = qau_pkg::FUNC_PRODUCT;
    req.a_w = '0; req.a_x = '0; req.a_y = '0; req.a_z = '0;
    req.b_w = '0; req.b_x = '0; req.b_y = '0; req.b_z = '0;
    rsp.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [W-1:0] pick_comp();
    logic signed [W-1:0] v;
    v = W'($urandom());
    case ($urandom_range(0, 3))
      0: case ($urandom_range(0, 5))
           0: v = 16'sh7fff;
           1: v = 16'sh8000;
           2: v = 16'sh0000;
           3: v = 16'sh4000;
           4: v = 16'shc000;
           default: v = 16'shffff;
         endcase
      1: v = v >>> $urandom_range(4, 15);
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_quat(qau_pkg::func_t fn, logic signed [W-1:0] q [8]);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func  <= fn;
    req.a_w <= q[0]; req.a_x <= q[1]; req.a_y <= q[2]; req.a_z <= q[3];
    req.b_w <= q[4]; req.b_x <= q[5]; req.b_y <= q[6]; req.b_z <= q[7];
    do @(posedge clk); while (!req.ready);
  endtask

  // sender
  initial begin
    logic signed [W-1:0] q [8];
    qau_pkg::func_t fn;
    @(negedge rst);
    @(posedge clk);
    q = '{default: 16'sh7fff}; send_quat(qau_pkg::FUNC_PRODUCT, q);
    q = '{default: 16'sh8000}; send_quat(qau_pkg::FUNC_PRODUCT, q);
    q = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
          16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
    send_quat(qau_pkg::FUNC_PRODUCT, q);
    q = '{16'sh4000, 0, 0, 0, 16'sh0001, 16'sh0002, 16'sh0003, 16'sh0004};
    send_quat(qau_pkg::FUNC_PRODUCT, q);
    q = '{0, 16'sh0001, 0, 0, 0, 16'sh0001, 0, 0}; send_quat(qau_pkg::FUNC_PRODUCT, q);
    q = '{16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001, 16'sh2000, 0, 0, 0};
    send_quat(qau_pkg::FUNC_PRODUCT, q);
    q = '{default: 16'sh0000}; send_quat(qau_pkg::FUNC_NORMALIZE, q);
    q = '{default: 16'sh7fff}; send_quat(qau_pkg::FUNC_NORMALIZE, q);
    q = '{default: 16'sh8000}; send_quat(qau_pkg::FUNC_NORMALIZE, q);
    q = '{16'sh0001, 0, 0, 0, 16'sh1234, 16'sh1234, 16'sh1234, 16'sh1234};
    send_quat(qau_pkg::FUNC_NORMALIZE, q);
    q = '{0, 0, 0, 16'sh8000, 0, 0, 0, 0}; send_quat(qau_pkg::FUNC_NORMALIZE, q);
    q = '{16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001, 0, 0, 0, 0};
    send_quat(qau_pkg::FUNC_NORMALIZE, q);
    q = '{16'sh0003, 16'shfffc, 0, 0, 0, 0, 0, 0}; send_quat(qau_pkg::FUNC_NORMALIZE, q);
    q = '{default: 16'sh8000}; send_quat(qau_pkg::FUNC_CONJUGATE, q);
    q = '{default: 16'sh7fff}; send_quat(qau_pkg::FUNC_CONJUGATE, q);
    q = '{16'sh0000, 16'sh0001, 16'shffff, 16'sh8000,
          16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555};
    send_quat(qau_pkg::FUNC_CONJUGATE, q);
    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(0, 2))
        0: fn = qau_pkg::FUNC_PRODUCT;
        1: fn = qau_pkg::FUNC_NORMALIZE;
        default: fn = qau_pkg::FUNC_CONJUGATE;
      endcase
      for (int i = 0; i < 8; i++) q[i] = pick_comp();
      send_quat(fn, q);
    end
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // receiver, with one long hold-off to back the pipeline up
  initial begin
    int gap;
    n_rsp = 0;
    @(negedge rst);
    forever begin
      gap = (n_rsp == 300) ? HOLD_CYCLES : $urandom_range(0, 3);
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      n_rsp++;
    end
  end
endmodule
